FILE: design/wsfbt_pkg.sv
package wsfbt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int BLOCK_BITS_DEF    = 16;
    localparam int COUNT_BITS_DEF    = 24;

    localparam int OP_BITS        = 3;
    localparam int DIE_BITS       = 8;
    localparam int STATUS_BITS    = 2;
    localparam int THR_BITS       = 24;
    localparam int DC_BITS        = 5;
    localparam int REM_BITS       = 5;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [OP_BITS-1:0] OP_GET   = 3'd0;
    localparam logic [OP_BITS-1:0] OP_PUT   = 3'd1;
    localparam logic [OP_BITS-1:0] OP_SWAP  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_MAX   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_ERASE_FAIL = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY      = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_NONE       = 2'd3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WEAR_THRESHOLD = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIE_COUNT      = 8'd1;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic find_start;
        logic apply;
    } wsfbt_cmd_t;

    typedef struct packed {
        logic mod_last;
        logic find_done;
        logic out_free;
    } wsfbt_stat_t;

    // one restoring step of a bit-serial residue, r < dc <= 31
    function automatic logic [REM_BITS-1:0] mod_step(
        input logic [REM_BITS-1:0] r,
        input logic                b,
        input logic [DC_BITS-1:0]  dc
    );
        logic [REM_BITS:0] t;
        t = {r, b};
        if (t >= {1'b0, dc})
        begin
            t = t - {1'b0, dc};
        end
        return t[REM_BITS-1:0];
    endfunction

endpackage

FILE: design/wsfbt_if.sv
interface wsfbt_req_if
    import wsfbt_pkg::*;
#(
    parameter int BLOCK_BITS = BLOCK_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [OP_BITS-1:0]    op;
    logic [DIE_BITS-1:0]   die;
    logic                  erase_ok;
    logic [BLOCK_BITS-1:0] in_block;
    logic [COUNT_BITS-1:0] in_ec;

    modport source (output valid, op, die, erase_ok, in_block, in_ec, input ready);
    modport sink   (input valid, op, die, erase_ok, in_block, in_ec, output ready);
endinterface

interface wsfbt_rsp_if
    import wsfbt_pkg::*;
#(
    parameter int BLOCK_BITS = BLOCK_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [BLOCK_BITS-1:0]  out_block;
    logic [COUNT_BITS-1:0]  out_ec;

    modport source (output valid, status, out_block, out_ec, input ready);
    modport sink   (input valid, status, out_block, out_ec, output ready);
endinterface

interface wsfbt_cfg_if
    import wsfbt_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/wsfbt_tree.sv
module wsfbt_tree
    import wsfbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int BLOCK_BITS    = BLOCK_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    localparam int IW           = $clog2(TABLE_ENTRIES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  flag [TABLE_ENTRIES],
    input  logic [BLOCK_BITS-1:0] blk  [TABLE_ENTRIES],
    input  logic [COUNT_BITS-1:0] cnt  [TABLE_ENTRIES],
    output logic                  done,
    output logic                  any,
    output logic [IW-1:0]         idx,
    output logic [BLOCK_BITS-1:0] root_blk,
    output logic [COUNT_BITS-1:0] root_cnt
);

    localparam int P = 1 << IW;

    typedef struct packed {
        logic                  any;
        logic [IW-1:0]         idx;
        logic [BLOCK_BITS-1:0] blk;
        logic [COUNT_BITS-1:0] cnt;
    } node_t;

    // heap order: node k has children 2k+1 and 2k+2, leaves from P-1
    node_t         node_reg [2*P-1];
    logic [IW:0]   token_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < P; i++)
        begin
            if (i < TABLE_ENTRIES)
            begin
                node_reg[P-1+i] <= '{any: flag[i], idx: IW'(i), blk: blk[i], cnt: cnt[i]};
            end
            else
            begin
                node_reg[P-1+i] <= '0;
            end
        end
        for (int k = 0; k < P-1; k++)
        begin
            // lower index wins
            if (node_reg[2*k+1].any)
            begin
                node_reg[k] <= node_reg[2*k+1];
            end
            else
            begin
                node_reg[k] <= node_reg[2*k+2];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= '0;
        end
        else
        begin
            token_reg <= {token_reg[IW-1:0], start};
        end
    end

    assign done     = token_reg[IW];
    assign any      = node_reg[0].any;
    assign idx      = node_reg[0].idx;
    assign root_blk = node_reg[0].blk;
    assign root_cnt = node_reg[0].cnt;

endmodule

FILE: design/wsfbt_ctrl.sv
module wsfbt_ctrl
    import wsfbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [OP_BITS-1:0] req_op,
    output logic               req_ready,
    input  wsfbt_stat_t        stat,
    output wsfbt_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_LAUNCH,
        S_WAIT,
        S_APPLY
    } state_t;

    state_t state_reg;
    logic   accept;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        cmd            = '0;
        cmd.load       = accept;
        cmd.mod_step   = (state_reg == S_MOD);
        cmd.find_start = (state_reg == S_LAUNCH);
        cmd.apply      = (state_reg == S_APPLY) && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (req_op == OP_GET)
                        begin
                            state_reg <= S_MOD;
                        end
                        else if (req_op == OP_SWAP || req_op == OP_MAX)
                        begin
                            state_reg <= S_LAUNCH;
                        end
                        else
                        begin
                            state_reg <= S_APPLY;
                        end
                    end
                end
                S_MOD:
                begin
                    if (stat.mod_last)
                    begin
                        state_reg <= S_LAUNCH;
                    end
                end
                S_LAUNCH:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (stat.find_done)
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (stat.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/wsfbt_datapath.sv
module wsfbt_datapath
    import wsfbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int BLOCK_BITS    = BLOCK_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wsfbt_cmd_t             cmd,
    output wsfbt_stat_t            stat,
    input  logic [OP_BITS-1:0]     op,
    input  logic [DIE_BITS-1:0]    die,
    input  logic                   erase_ok,
    input  logic [BLOCK_BITS-1:0]  in_block,
    input  logic [COUNT_BITS-1:0]  in_ec,
    input  logic [THR_BITS-1:0]    threshold,
    input  logic [DC_BITS-1:0]     dc,
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic [STATUS_BITS-1:0] rsp_status,
    output logic [BLOCK_BITS-1:0]  rsp_block,
    output logic [COUNT_BITS-1:0]  rsp_ec
);

    localparam int N   = TABLE_ENTRIES;
    localparam int IW  = $clog2(N);
    localparam int BPW = $clog2(BLOCK_BITS);
    localparam int CW  = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

    // cell row
    logic [BLOCK_BITS-1:0] blk_reg  [N];
    logic [COUNT_BITS-1:0] cnt_reg  [N];
    logic [REM_BITS-1:0]   rem_reg  [N];
    logic [BLOCK_BITS-1:0] blk_next [N];
    logic [COUNT_BITS-1:0] cnt_next [N];
    logic                  valid    [N];
    logic                  flag     [N];
    logic                  gts      [N];

    // latched item
    logic [OP_BITS-1:0]    op_reg;
    logic [DIE_BITS-1:0]   die_reg;
    logic                  ok_reg;
    logic [BLOCK_BITS-1:0] blkin_reg;
    logic [COUNT_BITS-1:0] ecin_reg;
    logic [REM_BITS-1:0]   die_rem_reg;
    logic [BPW-1:0]        bitpos_reg;

    logic                  out_valid_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [BLOCK_BITS-1:0] oblk_reg;
    logic [COUNT_BITS-1:0] oec_reg;
    logic [STATUS_BITS-1:0] status_next;
    logic [BLOCK_BITS-1:0] oblk_next;
    logic [COUNT_BITS-1:0] oec_next;

    logic                  t_done;
    logic                  t_any;
    logic [IW-1:0]         t_idx;
    logic [BLOCK_BITS-1:0] t_blk;
    logic [COUNT_BITS-1:0] t_cnt;

    logic [IW-1:0]         pick_idx;
    logic [BLOCK_BITS-1:0] pick_blk;
    logic [COUNT_BITS-1:0] pick_cnt;
    logic                  pick_valid;
    logic                  swap_do;
    logic [COUNT_BITS-1:0] gap;
    logic [IW-1:0]         top_sel;
    logic                  insert_en;
    logic                  remove_en;
    logic                  clear_en;
    logic                  die_bit;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            valid[i] = (cnt_reg[i] != '1);
        end
        for (int i = 0; i < N; i++)
        begin
            if (op_reg == OP_GET)
            begin
                flag[i] = valid[i] && (rem_reg[i] == die_rem_reg);
            end
            else if (i == N-1)
            begin
                flag[i] = valid[i];
            end
            else
            begin
                // highest valid: valid entries form a prefix
                flag[i] = valid[i] && !valid[i+1];
            end
        end
    end

    wsfbt_tree #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BLOCK_BITS    (BLOCK_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_tree (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.find_start),
        .flag     (flag),
        .blk      (blk_reg),
        .cnt      (cnt_reg),
        .done     (t_done),
        .any      (t_any),
        .idx      (t_idx),
        .root_blk (t_blk),
        .root_cnt (t_cnt)
    );

    always_comb
    begin
        // no die match: fall back to the head entry
        pick_idx   = t_any ? t_idx : '0;
        pick_blk   = t_any ? t_blk : blk_reg[0];
        pick_cnt   = t_any ? t_cnt : cnt_reg[0];
        pick_valid = (pick_cnt != '1);

        gap     = t_cnt - ecin_reg;
        swap_do = (op_reg == OP_SWAP) && t_any && (t_cnt > ecin_reg)
                  && (CW'(gap) > CW'(threshold));
        top_sel   = (op_reg == OP_PUT) ? IW'(N-1) : t_idx;
        insert_en = (op_reg == OP_PUT) || swap_do;
        remove_en = (op_reg == OP_GET) && pick_valid;
        clear_en  = (op_reg == OP_CLEAR);

        for (int i = 0; i < N; i++)
        begin
            if (IW'(i) < top_sel)
            begin
                gts[i] = (cnt_reg[i] > ecin_reg);
            end
            else
            begin
                gts[i] = (IW'(i) == top_sel);
            end
        end

        for (int i = 0; i < N; i++)
        begin
            blk_next[i] = blk_reg[i];
            cnt_next[i] = cnt_reg[i];
            if (clear_en)
            begin
                blk_next[i] = '1;
                cnt_next[i] = '1;
            end
            else if (remove_en && (IW'(i) >= pick_idx))
            begin
                if (i == N-1)
                begin
                    blk_next[i] = '1;
                    cnt_next[i] = '1;
                end
                else
                begin
                    blk_next[i] = blk_reg[i+1];
                    cnt_next[i] = cnt_reg[i+1];
                end
            end
            else if (insert_en && (IW'(i) <= top_sel))
            begin
                if (i > 0 && gts[i-1])
                begin
                    blk_next[i] = blk_reg[i-1];
                    cnt_next[i] = cnt_reg[i-1];
                end
                else if (gts[i])
                begin
                    blk_next[i] = blkin_reg;
                    cnt_next[i] = ecin_reg;
                end
            end
        end

        status_next = ST_NONE;
        oblk_next   = '0;
        oec_next    = '0;
        unique case (op_reg)
            OP_GET:
            begin
                if (!pick_valid)
                begin
                    status_next = ST_EMPTY;
                end
                else if (ok_reg)
                begin
                    status_next = ST_OK;
                    oblk_next   = pick_blk;
                    oec_next    = pick_cnt + 1'b1;
                end
                else
                begin
                    status_next = ST_ERASE_FAIL;
                    oblk_next   = pick_blk;
                end
            end
            OP_PUT:
            begin
                status_next = ST_OK;
            end
            OP_SWAP:
            begin
                status_next = swap_do ? ST_OK : ST_NONE;
            end
            OP_MAX:
            begin
                if (t_any)
                begin
                    status_next = ST_OK;
                    oblk_next   = t_blk;
                    oec_next    = t_cnt;
                end
            end
            OP_CLEAR:
            begin
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_NONE;
            end
        endcase
    end

    assign die_bit = (int'(bitpos_reg) < DIE_BITS) ? die_reg[bitpos_reg[2:0]] : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                cnt_reg[i] <= '1;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                for (int i = 0; i < N; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
            if (cmd.apply)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            for (int i = 0; i < N; i++)
            begin
                blk_reg[i] <= blk_next[i];
            end
            status_reg <= status_next;
            oblk_reg   <= oblk_next;
            oec_reg    <= oec_next;
        end
        if (cmd.load)
        begin
            op_reg      <= op;
            die_reg     <= die;
            ok_reg      <= erase_ok;
            blkin_reg   <= in_block;
            ecin_reg    <= in_ec;
            die_rem_reg <= '0;
            bitpos_reg  <= BPW'(BLOCK_BITS-1);
            for (int i = 0; i < N; i++)
            begin
                rem_reg[i] <= '0;
            end
        end
        else if (cmd.mod_step)
        begin
            // residues MSB first, one bit per cycle in every cell
            die_rem_reg <= mod_step(die_rem_reg, die_bit, dc);
            bitpos_reg  <= bitpos_reg - 1'b1;
            for (int i = 0; i < N; i++)
            begin
                rem_reg[i] <= mod_step(rem_reg[i], blk_reg[i][bitpos_reg], dc);
            end
        end
    end

    assign stat.mod_last  = (bitpos_reg == '0);
    assign stat.find_done = t_done;
    assign stat.out_free  = !out_valid_reg || rsp_ready;

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = status_reg;
    assign rsp_block  = oblk_reg;
    assign rsp_ec     = oec_reg;

endmodule

FILE: design/wear_sorted_free_block_table.sv
// Free flash block table kept sorted by erase count, invalid entries at the tail.
// req channel: one transfer per command (op, die, erase_ok, in_block, in_ec).
//   get / put / swap / max query / clear. rsp channel: one transfer per
//   command (status, out_block, out_ec). cfg channel: index 0 wear_threshold,
//   index 1 die_count; always ready, write only while no command is in flight.
// One command at a time. Path from req transfer to rsp valid:
//   put, clear, unknown op: straight to the apply step
//   swap, max query:        registered find tree, then the apply step
//   get:                    residue steps, find tree, apply step; the
//                           die residue of every entry is formed bit-serially,
//                           then the find tree picks the first match.
// req is ready again once the result is written to the output register, so a
// new command can be accepted while rsp still waits.
// If rsp stalls, a finished command holds in its last step until the output
// register frees up.
// Reset: table all invalid, wear_threshold 100, die_count 1.
module wear_sorted_free_block_table
    import wsfbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int BLOCK_BITS    = BLOCK_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    wsfbt_req_if.sink  req,
    wsfbt_rsp_if.source rsp,
    wsfbt_cfg_if.sink  cfg
);

    logic [THR_BITS-1:0] thr_reg;
    logic [DC_BITS-1:0]  dc_reg;
    logic [DC_BITS-1:0]  dc_eff;
    wsfbt_cmd_t          cmd;
    wsfbt_stat_t         stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_BITS'(100);
            dc_reg  <= DC_BITS'(1);
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_WEAR_THRESHOLD)
            begin
                thr_reg <= cfg.data[THR_BITS-1:0];
            end
            else if (cfg.index == REG_DIE_COUNT)
            begin
                dc_reg <= cfg.data[DC_BITS-1:0];
            end
        end
    end

    // zero dies behaves as one
    assign dc_eff = (dc_reg == '0) ? DC_BITS'(1) : dc_reg;

    wsfbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_op    (req.op),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wsfbt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BLOCK_BITS    (BLOCK_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (req.op),
        .die        (req.die),
        .erase_ok   (req.erase_ok),
        .in_block   (req.in_block),
        .in_ec      (req.in_ec),
        .threshold  (thr_reg),
        .dc         (dc_eff),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .rsp_status (rsp.status),
        .rsp_block  (rsp.out_block),
        .rsp_ec     (rsp.out_ec)
    );

endmodule
